### hdl/gn_pkg.sv
`timescale 1ns / 1ps

package gn_pkg;

    // default table depth, a power of two from 16 to 256
    localparam int TABLE_SIZE_DEF = 256;

    // datapath widths
    localparam int FRAC_W = 16;     // Q0.16 fraction
    localparam int GRAD_W = 16;     // Q1.14 gradient component
    localparam int PROD_W = 33;     // offset times gradient
    localparam int ACC_W  = 40;     // dot products and blend values
    localparam int OUT_W  = 19;     // Q2.16 result
    localparam int OUT_SHIFT = 14;  // Q.30 to Q.16
    localparam int CORNERS = 8;

    typedef enum logic [2:0] {
        CMD_EVAL1     = 3'd0,
        CMD_EVAL2     = 3'd1,
        CMD_EVAL3     = 3'd2,
        CMD_LOAD_PERM = 3'd3,
        CMD_LOAD_G1   = 3'd4,
        CMD_LOAD_G2   = 3'd5,
        CMD_LOAD_G3   = 3'd6
    } t_cmd;

    function automatic logic is_eval(input logic [2:0] cmd);
        return (cmd == CMD_EVAL1) || (cmd == CMD_EVAL2) || (cmd == CMD_EVAL3);
    endfunction

endpackage

### hdl/gradient_noise_1d_2d_3d_unit.sv
`timescale 1ns / 1ps
// channel   valid     ready     payload
// input     i_valid   o_ready   i_command, i_coord_x/y/z, i_entry_index,
//                               i_perm_value, i_grad_a/b/c
// output    o_valid   i_ready   o_noise_value
//
// one command enters per clock while the output is not stalled; an evaluate
// command leaves through the output register after the two permutation
// lookups, the gradient lookup, the offset products, the dot products and
// three levels of blending (each a subtract, a multiply and an add stage)
// load commands give no transfer on the output side
// reset clears only the valid bits; table contents stay undefined until loaded
// a stalled output freezes every stage, so nothing is dropped or repeated

module gradient_noise_1d_2d_3d_unit #(
    parameter int TABLE_SIZE = gn_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_command,
    input  logic signed [31:0]            i_coord_x,
    input  logic signed [31:0]            i_coord_y,
    input  logic signed [31:0]            i_coord_z,
    input  logic [7:0]                    i_entry_index,
    input  logic [7:0]                    i_perm_value,
    input  logic signed [15:0]            i_grad_a,
    input  logic signed [15:0]            i_grad_b,
    input  logic signed [15:0]            i_grad_c,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [gn_pkg::OUT_W-1:0] o_noise_value
);
    import gn_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // smoothing weights travelling with an item
    typedef struct packed {
        logic [FRAC_W-1:0] sx;
        logic [FRAC_W-1:0] sy;
        logic [FRAC_W-1:0] sz;
    } t_sw;

    // pipeline enable: every stage moves unless the output register is held
    logic r_out_valid;
    logic en;
    logic acc;
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    logic [IW-1:0] w_x0, w_x1, w_idx;
    assign w_x0  = i_coord_x[FRAC_W +: IW];
    assign w_x1  = w_x0 + IW'(1);
    assign w_idx = IW'(i_entry_index);

    // ---------------- stage 1: first permutation lookup ----------------
    logic [7:0]          m_perm_a [TABLE_SIZE];
    logic                r1_valid;
    logic [2:0]          r1_cmd;
    logic [IW-1:0]       r1_idx, r1_y0, r1_y1, r1_z0, r1_z1;
    logic [7:0]          r1_pv, r1_i, r1_j;
    logic [GRAD_W-1:0]   r1_ga, r1_gb, r1_gc;
    logic [FRAC_W-1:0]   r1_fx, r1_fy, r1_fz;

    always_ff @(posedge i_clk) begin
        if (acc && i_command == CMD_LOAD_PERM) begin
            m_perm_a[w_idx] <= i_perm_value;
        end
        if (en) begin
            r1_i <= m_perm_a[w_x0];
            r1_j <= m_perm_a[w_x1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= i_command;
            r1_idx <= w_idx;
            r1_pv  <= i_perm_value;
            r1_ga  <= i_grad_a;
            r1_gb  <= i_grad_b;
            r1_gc  <= i_grad_c;
            r1_fx  <= i_coord_x[FRAC_W-1:0];
            r1_fy  <= i_coord_y[FRAC_W-1:0];
            r1_fz  <= i_coord_z[FRAC_W-1:0];
            r1_y0  <= i_coord_y[FRAC_W +: IW];
            r1_y1  <= i_coord_y[FRAC_W +: IW] + IW'(1);
            r1_z0  <= i_coord_z[FRAC_W +: IW];
            r1_z1  <= i_coord_z[FRAC_W +: IW] + IW'(1);
        end
    end

    // ---------------- stage 2: corner hashes, fraction squares ----------------
    // copy 0 hashes from P[x0], copy 1 from P[x1]; corner code is {y, x}
    logic [7:0]          m_perm_b [2][TABLE_SIZE];
    logic                r2_valid;
    logic [2:0]          r2_cmd;
    logic [IW-1:0]       r2_idx, r2_z0, r2_z1;
    logic [7:0]          r2_i, r2_j;
    logic [7:0]          r2_b [4];
    logic [GRAD_W-1:0]   r2_ga, r2_gb, r2_gc;
    logic [FRAC_W-1:0]   r2_fx, r2_fy, r2_fz;
    logic [2*FRAC_W-1:0] r2_ffx, r2_ffy, r2_ffz;

    for (genvar p = 0; p < 2; p++) begin : g_perm_b
        logic [IW-1:0] w_base;
        assign w_base = (p == 0) ? IW'(r1_i) : IW'(r1_j);
        always_ff @(posedge i_clk) begin
            if (en && r1_valid && r1_cmd == CMD_LOAD_PERM) begin
                m_perm_b[p][r1_idx] <= r1_pv;
            end
            if (en) begin
                r2_b[p]     <= m_perm_b[p][w_base + r1_y0];
                r2_b[p + 2] <= m_perm_b[p][w_base + r1_y1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd <= r1_cmd;
            r2_idx <= r1_idx;
            r2_i   <= r1_i;
            r2_j   <= r1_j;
            r2_z0  <= r1_z0;
            r2_z1  <= r1_z1;
            r2_ga  <= r1_ga;
            r2_gb  <= r1_gb;
            r2_gc  <= r1_gc;
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_fz  <= r1_fz;
            r2_ffx <= r1_fx * r1_fx;
            r2_ffy <= r1_fy * r1_fy;
            r2_ffz <= r1_fz * r1_fz;
        end
    end

    // ---------------- stage 3: gradient lookups, smooth weights ----------------
    logic [GRAD_W-1:0]   m_g1 [TABLE_SIZE];
    logic [2*GRAD_W-1:0] m_g2 [2][TABLE_SIZE];
    logic [3*GRAD_W-1:0] m_g3 [4][TABLE_SIZE];
    logic                r3_valid;
    logic [2:0]          r3_cmd;
    logic [GRAD_W-1:0]   r3_g1 [2];
    logic [2*GRAD_W-1:0] r3_g2 [4];
    logic [3*GRAD_W-1:0] r3_g3 [CORNERS];
    logic [FRAC_W-1:0]   r3_fx, r3_fy, r3_fz;
    t_sw                 r3_sw;

    always_ff @(posedge i_clk) begin
        if (en && r2_valid && r2_cmd == CMD_LOAD_G1) begin
            m_g1[r2_idx] <= r2_ga;
        end
        if (en) begin
            r3_g1[0] <= m_g1[IW'(r2_i)];
            r3_g1[1] <= m_g1[IW'(r2_j)];
        end
    end

    // copy q serves the corners {q, x} of the square
    for (genvar q = 0; q < 2; q++) begin : g_grad2
        always_ff @(posedge i_clk) begin
            if (en && r2_valid && r2_cmd == CMD_LOAD_G2) begin
                m_g2[q][r2_idx] <= {r2_gb, r2_ga};
            end
            if (en) begin
                r3_g2[2*q]     <= m_g2[q][IW'(r2_b[2*q])];
                r3_g2[2*q + 1] <= m_g2[q][IW'(r2_b[2*q + 1])];
            end
        end
    end

    // copy q serves corners {z, y, x} with {z, y} = q
    for (genvar q = 0; q < 4; q++) begin : g_grad3
        logic [IW-1:0] w_zc;
        assign w_zc = (q >= 2) ? r2_z1 : r2_z0;
        always_ff @(posedge i_clk) begin
            if (en && r2_valid && r2_cmd == CMD_LOAD_G3) begin
                m_g3[q][r2_idx] <= {r2_gc, r2_gb, r2_ga};
            end
            if (en) begin
                r3_g3[2*q]     <= m_g3[q][IW'(r2_b[2*(q%2)]) + w_zc];
                r3_g3[2*q + 1] <= m_g3[q][IW'(r2_b[2*(q%2) + 1]) + w_zc];
            end
        end
    end

    // s = f*f*(3 - 2f), product of the square and the slope term
    function automatic logic [FRAC_W-1:0] smooth_w(input logic [2*FRAC_W-1:0] ff,
                                                   input logic [FRAC_W-1:0] f);
        logic [FRAC_W+1:0]   k;
        logic [3*FRAC_W+1:0] prod;
        k    = 18'd196608 - {1'b0, f, 1'b0};
        prod = ff * k;
        return prod[2*FRAC_W +: FRAC_W];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd   <= r2_cmd;
            r3_fx    <= r2_fx;
            r3_fy    <= r2_fy;
            r3_fz    <= r2_fz;
            r3_sw.sx <= smooth_w(r2_ffx, r2_fx);
            r3_sw.sy <= smooth_w(r2_ffy, r2_fy);
            r3_sw.sz <= smooth_w(r2_ffz, r2_fz);
        end
    end

    // ---------------- stage 4: offset times gradient ----------------
    // unused axes get zero gradients and zero weights, so the 3d tree
    // reduces to the 1d or 2d blend exactly
    logic signed [GRAD_W-1:0] w_g [CORNERS][3];
    logic signed [FRAC_W:0]   w_r [CORNERS][3];
    logic                     r4_valid;
    logic signed [PROD_W-1:0] r4_p [CORNERS][3];
    t_sw                      r4_sw;

    always_comb begin
        for (int k = 0; k < CORNERS; k++) begin
            w_r[k][0] = {k[0], r3_fx};
            w_r[k][1] = {k[1], r3_fy};
            w_r[k][2] = {k[2], r3_fz};
            w_g[k][0] = '0;
            w_g[k][1] = '0;
            w_g[k][2] = '0;
            case (r3_cmd)
                CMD_EVAL1: begin
                    if (k < 2) begin
                        w_g[k][0] = r3_g1[k];
                    end
                end
                CMD_EVAL2: begin
                    if (k < 4) begin
                        w_g[k][0] = r3_g2[k][GRAD_W-1:0];
                        w_g[k][1] = r3_g2[k][2*GRAD_W-1:GRAD_W];
                    end
                end
                default: begin
                    w_g[k][0] = r3_g3[k][GRAD_W-1:0];
                    w_g[k][1] = r3_g3[k][2*GRAD_W-1:GRAD_W];
                    w_g[k][2] = r3_g3[k][3*GRAD_W-1:2*GRAD_W];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < CORNERS; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r4_p[k][c] <= w_r[k][c] * w_g[k][c];
                end
            end
            r4_sw.sx <= r3_sw.sx;
            r4_sw.sy <= (r3_cmd == CMD_EVAL1) ? '0 : r3_sw.sy;
            r4_sw.sz <= (r3_cmd == CMD_EVAL3) ? r3_sw.sz : '0;
        end
    end

    // ---------------- stage 5: dot products ----------------
    logic                    r5_valid;
    logic signed [ACC_W-1:0] r5_d [CORNERS];
    t_sw                     r5_sw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < CORNERS; k++) begin
                r5_d[k] <= ACC_W'(r4_p[k][0]) + ACC_W'(r4_p[k][1]) + ACC_W'(r4_p[k][2]);
            end
            r5_sw <= r4_sw;
        end
    end

    // ---------------- stages 6 to 14: blend along x, y, z ----------------
    // each level: difference, weighted product, add back with floor shift
    localparam int MW = ACC_W + FRAC_W + 1;

    logic                    r6_valid, r7_valid, r8_valid;
    logic signed [ACC_W-1:0] r6_a [4], r6_d [4], r7_a [4], r8_v [4];
    logic signed [MW-1:0]    r7_p [4];
    t_sw                     r6_sw, r7_sw, r8_sw;

    logic                    r9_valid, r10_valid, r11_valid;
    logic signed [ACC_W-1:0] r9_a [2], r9_d [2], r10_a [2], r11_v [2];
    logic signed [MW-1:0]    r10_p [2];
    t_sw                     r9_sw, r10_sw, r11_sw;

    logic                    r12_valid, r13_valid, r14_valid;
    logic signed [ACC_W-1:0] r12_a, r12_d, r13_a, r14_v;
    logic signed [MW-1:0]    r13_p;
    logic [FRAC_W-1:0]       r12_sz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int n = 0; n < 4; n++) begin
                r6_a[n]  <= r5_d[2*n];
                r6_d[n]  <= r5_d[2*n + 1] - r5_d[2*n];
                r7_a[n]  <= r6_a[n];
                r7_p[n]  <= $signed({1'b0, r6_sw.sx}) * r6_d[n];
                r8_v[n]  <= r7_a[n] + ACC_W'(r7_p[n] >>> FRAC_W);
            end
            r6_sw <= r5_sw;
            r7_sw <= r6_sw;
            r8_sw <= r7_sw;
            // x-blended values come as {z, y}; pair y0 with y1 at each z
            for (int n = 0; n < 2; n++) begin
                r9_a[n]  <= r8_v[2*n];
                r9_d[n]  <= r8_v[2*n + 1] - r8_v[2*n];
                r10_a[n] <= r9_a[n];
                r10_p[n] <= $signed({1'b0, r9_sw.sy}) * r9_d[n];
                r11_v[n] <= r10_a[n] + ACC_W'(r10_p[n] >>> FRAC_W);
            end
            r9_sw  <= r8_sw;
            r10_sw <= r9_sw;
            r11_sw <= r10_sw;
            r12_a  <= r11_v[0];
            r12_d  <= r11_v[1] - r11_v[0];
            r12_sz <= r11_sw.sz;
            r13_a  <= r12_a;
            r13_p  <= $signed({1'b0, r12_sz}) * r12_d;
            r14_v  <= r13_a + ACC_W'(r13_p >>> FRAC_W);
        end
    end

    // ---------------- stage 15: scale, saturate, output register ----------------
    logic signed [ACC_W-OUT_SHIFT-1:0] w_scaled;
    logic signed [OUT_W-1:0]           w_sat;
    logic signed [OUT_W-1:0]           r_out_noise;

    assign w_scaled = r14_v[ACC_W-1:OUT_SHIFT];

    always_comb begin
        if (w_scaled > (ACC_W-OUT_SHIFT)'(SAT_MAX)) begin
            w_sat = SAT_MAX;
        end else if (w_scaled < (ACC_W-OUT_SHIFT)'(SAT_MIN)) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_scaled[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_noise <= w_sat;
        end
    end

    // valid bits; loads drop out once their last table write is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r8_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            r10_valid   <= 1'b0;
            r11_valid   <= 1'b0;
            r12_valid   <= 1'b0;
            r13_valid   <= 1'b0;
            r14_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= acc;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid && is_eval(r2_cmd);
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r7_valid    <= r6_valid;
            r8_valid    <= r7_valid;
            r9_valid    <= r8_valid;
            r10_valid   <= r9_valid;
            r11_valid   <= r10_valid;
            r12_valid   <= r11_valid;
            r13_valid   <= r12_valid;
            r14_valid   <= r13_valid;
            r_out_valid <= r14_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_noise;

endmodule

### hdl/gn_chk.sv
`timescale 1ns / 1ps

module gn_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [2:0]                      i_command,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic signed [gn_pkg::OUT_W-1:0] o_noise_value
);
    import gn_pkg::*;

    // evaluate commands taken in and not yet delivered
    logic [7:0] r_inflight;
    logic [7:0] n_inflight;

    always_comb begin
        n_inflight = r_inflight;
        if (i_valid && o_ready && is_eval(i_command)) begin
            n_inflight = n_inflight + 8'd1;
        end
        if (o_valid && i_ready) begin
            n_inflight = n_inflight - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value))
        else $error("output changed while stalled");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input blocked without an output stall");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != 8'd0)
        else $error("result without a pending evaluate");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 8'd0 |-> !o_valid)
        else $error("result appeared with nothing pending");

endmodule

bind gradient_noise_1d_2d_3d_unit gn_chk u_gn_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_noise_value (o_noise_value)
);
